// ===== hw/rtl/csgs_pkg.sv =====
// Shared types and constants for the cubic spline Gauss-Seidel solver.
// No dependencies; imported by csgs_div, csgs_dp, csgs_ctrl and the top module.
`timescale 1ns / 1ps
`default_nettype none

package csgs_pkg;

    localparam int FRAC_BITS  = 16;   // knot format Q15.16
    localparam int RELAX_FRAC = 16;   // relaxation factor is always unsigned Q1.16
    localparam int IDX_W      = 6;    // knot index field
    localparam int CFG_AW     = 4;    // byte address of three 32-bit registers

    // divider sizes: 67-bit signed dividend, 35-bit divisor, 50 quotient bits
    localparam int NUM_W = 67;
    localparam int DEN_W = 35;
    localparam int QB    = 50;
    localparam int Q_W   = QB + 1;

    localparam logic [1:0] STAT_CONVERGED = 2'd0;
    localparam logic [1:0] STAT_LIMIT     = 2'd1;
    localparam logic [1:0] STAT_FEW       = 2'd2;
    localparam logic [1:0] STAT_SPACING   = 2'd3;

    localparam logic [1:0] REG_ITER  = 2'd0;
    localparam logic [1:0] REG_TOL   = 2'd1;
    localparam logic [1:0] REG_RELAX = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_STORE,
        OP_P_LATCH, OP_P_DIV, OP_P_FIRST, OP_P_RHS,
        OP_S_A, OP_S_B, OP_S_C, OP_S_MUL1, OP_S_MUL2, OP_S_SUM, OP_S_DIV,
        OP_S_SAT, OP_S_DIFF, OP_S_RELAX, OP_S_ROUND, OP_S_WRITE,
        OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        ST_LOAD, ST_START,
        ST_P_RD, ST_P_LAT, ST_P_DIV, ST_P_WAIT, ST_P_STORE,
        ST_SW_INIT,
        ST_S_RD, ST_S_A, ST_S_B, ST_S_C, ST_S_MUL1, ST_S_MUL2, ST_S_SUM,
        ST_S_DIV, ST_S_WAIT, ST_S_SAT, ST_S_DIFF, ST_S_RELAX, ST_S_ROUND,
        ST_S_WRITE, ST_S_END,
        ST_O_RD, ST_O_PUT, ST_ERR
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] addr;
        logic             zero;    // read data counts as zero
        logic [1:0]       status;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic h_bad;        // spacing zero or negative
        logic big_change;   // |M_old - S| above tolerance
        logic out_busy;     // output register full and not taken
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] v);
        logic signed [31:0] r;
        if (v[NUM_W-1:31] == '0 || v[NUM_W-1:31] == '1) begin
            r = v[31:0];
        end else if (v[NUM_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/csgs_div.sv =====
// Radix-2 restoring floor divider, one quotient bit per cycle.
// Depends on csgs_pkg for sizes.
`timescale 1ns / 1ps
`default_nettype none

module csgs_div
    import csgs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic        [DEN_W-1:0] i_den,
    output logic                         o_busy,
    output logic signed      [Q_W-1:0]   o_q,     // floor(num / den)
    output logic                         o_ovf    // |quotient| needs more than QB bits
);

    localparam int CNT_W = $clog2(QB);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QB-1:0]    r_lo;
    logic [QB-1:0]    r_q;
    logic             r_neg;
    logic             r_ovf;

    logic [NUM_W-1:0] w_u;      // floor(n/d) = ~floor(~n/d) for negative n
    logic [DEN_W-1:0] w_top;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_u     = i_num[NUM_W-1] ? ~i_num : i_num;
    assign w_top   = DEN_W'(w_u[NUM_W-2:QB]);
    assign w_trial = {r_rem, r_lo[QB-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(QB - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= w_top;
            r_lo  <= w_u[QB-1:0];
            r_q   <= '0;
            r_neg <= i_num[NUM_W-1];
            r_ovf <= w_top >= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            r_lo  <= {r_lo[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_neg ? ~{1'b0, r_q} : {1'b0, r_q};
    assign o_ovf  = r_ovf;

    a_fixed_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ##(QB-1) r_busy ##1 !r_busy)
        else $error("divider run length wrong");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/csgs_dp.sv =====
// Datapath: knot, slope-difference and moment memories, shared multiplier,
// shared divider and output register. Depends on csgs_pkg, csgs_ram, csgs_div.
`timescale 1ns / 1ps
`default_nettype none

module csgs_dp
    import csgs_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic        [16:0] i_relax,
    input  wire logic        [15:0] i_tol,
    input  wire logic signed [31:0] i_knot_x,
    input  wire logic signed [31:0] i_knot_y,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [IDX_W-1:0]        o_out_idx,
    output logic signed [31:0]      o_out_sd,
    output logic [1:0]              o_out_stat,
    output logic                    o_out_last
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int A_W = 52;
    localparam int P_W = 66;
    localparam int I_W = 35;

    logic [AW-1:0] w_addr;
    assign w_addr = i_cmd.addr[AW-1:0];

    logic [31:0] w_x_rd, w_y_rd, w_m_rd, w_rhs_rd;
    logic        w_rhs_we, w_m_we, w_xy_we;
    logic [31:0] w_rhs_wd, w_m_wd;

    // operand registers
    logic signed [31:0]    r_xa, r_ya, r_xb, r_ma, r_mold, r_mc, r_rhs, r_s;
    logic signed [32:0]    r_h1, r_h2, r_diff;
    logic signed [P_W-1:0] r_p, r_p2, r_t;
    logic signed [A_W-1:0] r_a;
    logic [DEN_W-1:0]      r_d;
    logic signed [Q_W-1:0] r_prev;
    logic signed [I_W-1:0] r_inc;

    logic signed [31:0] w_m_eff;
    assign w_m_eff = i_cmd.zero ? 32'sd0 : $signed(w_m_rd);

    assign w_xy_we = i_cmd.op == OP_STORE;

    csgs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(w_xy_we), .i_waddr(w_addr), .i_wdata(i_knot_x),
        .i_raddr(w_addr), .o_rdata(w_x_rd));

    csgs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(w_xy_we), .i_waddr(w_addr), .i_wdata(i_knot_y),
        .i_raddr(w_addr), .o_rdata(w_y_rd));

    csgs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_rhs_ram (
        .i_clk(i_clk), .i_we(w_rhs_we), .i_waddr(w_addr), .i_wdata(w_rhs_wd),
        .i_raddr(w_addr), .o_rdata(w_rhs_rd));

    csgs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_m_ram (
        .i_clk(i_clk), .i_we(w_m_we), .i_waddr(w_addr), .i_wdata(w_m_wd),
        .i_raddr(w_addr), .o_rdata(w_m_rd));

    // spacing and ordinate step during preparation
    logic signed [32:0] w_h, w_dy;
    assign w_h  = 33'($signed(w_x_rd)) - 33'(r_xa);
    assign w_dy = 33'($signed(w_y_rd)) - 33'(r_ya);

    // divider: slope (dy*2^F + h/2) / h, or sweep (a - t) / (2*(h1+h2))
    logic                    w_div_start, w_div_busy, w_div_ovf;
    logic signed [NUM_W-1:0] w_num;
    logic [DEN_W-1:0]        w_den;
    logic signed [Q_W-1:0]   w_q;

    assign w_div_start = i_cmd.op == OP_P_DIV || i_cmd.op == OP_S_DIV;

    always_comb begin
        if (i_cmd.op == OP_P_DIV) begin
            w_num = (NUM_W'(w_dy) <<< FRAC_BITS) + NUM_W'(w_h >>> 1);
            w_den = DEN_W'($unsigned(w_h));
        end else begin
            w_num = NUM_W'(r_a) - NUM_W'(r_t);
            w_den = r_d;
        end
    end

    csgs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den),
        .o_busy(w_div_busy), .o_q(w_q), .o_ovf(w_div_ovf));

    // shared multiplier
    logic signed [33:0] w_mul_a, w_mul_b;
    logic signed [67:0] w_prod;

    always_comb begin
        case (i_cmd.op)
            OP_S_MUL1: begin
                w_mul_a = 34'(r_h1);
                w_mul_b = 34'(r_ma);
            end
            OP_S_MUL2: begin
                w_mul_a = 34'(r_h2);
                w_mul_b = 34'(r_mc);
            end
            default: begin
                w_mul_a = 34'($signed({1'b0, i_relax}));
                w_mul_b = 34'(r_diff);
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    logic signed [33:0] w_hsum;
    assign w_hsum = 34'(r_h1) + 34'(r_h2);

    logic signed [31:0] w_s_sat;
    always_comb begin
        if (w_div_ovf) begin
            w_s_sat = w_q[Q_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_s_sat = sat32(NUM_W'(w_q));
        end
    end

    assign w_rhs_we = i_cmd.op == OP_P_RHS;
    assign w_rhs_wd = sat32(NUM_W'(w_q) - NUM_W'(r_prev));
    assign w_m_we   = i_cmd.op == OP_S_WRITE;
    assign w_m_wd   = sat32(NUM_W'(r_mold) + NUM_W'(r_inc));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_P_LATCH: begin
                r_xa <= w_x_rd;
                r_ya <= w_y_rd;
            end
            OP_P_FIRST, OP_P_RHS: r_prev <= w_q;
            OP_S_A: begin
                r_xa <= w_x_rd;
                r_ma <= w_m_eff;
            end
            OP_S_B: begin
                r_xb   <= w_x_rd;
                r_mold <= w_m_eff;
                r_rhs  <= w_rhs_rd;
            end
            OP_S_C: begin
                r_h1 <= 33'(r_xb) - 33'(r_xa);
                r_h2 <= 33'($signed(w_x_rd)) - 33'(r_xb);
                r_mc <= w_m_eff;
            end
            OP_S_MUL1: begin
                r_p <= w_prod[P_W-1:0];
                // 6*2^F*rhs + (h1+h2), the rounding half of the divisor
                r_a <= (A_W'(r_rhs) <<< (FRAC_BITS + 2)) + (A_W'(r_rhs) <<< (FRAC_BITS + 1))
                     + A_W'(w_hsum);
                r_d <= {w_hsum[33:0], 1'b0};
            end
            OP_S_MUL2:  r_p2   <= w_prod[P_W-1:0];
            OP_S_SUM:   r_t    <= r_p + r_p2;
            OP_S_SAT:   r_s    <= w_s_sat;
            OP_S_DIFF:  r_diff <= 33'(r_s) - 33'(r_mold);
            OP_S_RELAX: r_p    <= w_prod[P_W-1:0];
            OP_S_ROUND: r_inc  <= I_W'((r_p + P_W'(32768)) >>> RELAX_FRAC);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            o_out_idx  <= i_cmd.addr;
            o_out_sd   <= w_m_eff;
            o_out_stat <= i_cmd.status;
            o_out_last <= i_cmd.last;
        end
    end

    logic signed [32:0] w_abs_diff;
    assign w_abs_diff = r_diff[32] ? -r_diff : r_diff;

    assign o_stat.div_busy   = w_div_busy;
    assign o_stat.h_bad      = w_h[32] || w_h == '0;
    assign o_stat.big_change = $unsigned(w_abs_diff) > 33'(i_tol);
    assign o_stat.out_busy   = o_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/csgs_ctrl.sv =====
// Sequencer for load, slope preparation, Gauss-Seidel sweeps and result output.
// Depends on csgs_pkg; drives csgs_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps
`default_nettype none

module csgs_ctrl
    import csgs_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_last,
    output logic            o_in_ready,
    input  wire logic [7:0] i_limit,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_m, n_m, r_i, n_i;
    logic [7:0]       r_sweep, n_sweep;
    logic             r_ok, n_ok, r_first, n_first;
    logic [1:0]       r_err, n_err, r_stat, n_stat;

    logic w_room, w_i_last, w_i_one;
    assign w_room   = r_cnt < MAX_CNT;
    assign w_i_last = r_i == r_m - CNT_W'(2);
    assign w_i_one  = r_i == CNT_W'(1);

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_m     = r_m;
        n_i     = r_i;
        n_sweep = r_sweep;
        n_ok    = r_ok;
        n_first = r_first;
        n_err   = r_err;
        n_stat  = r_stat;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (w_room) n_cnt = r_cnt + CNT_W'(1);
                    if (i_in_last) begin
                        n_m     = w_room ? r_cnt + CNT_W'(1) : r_cnt;
                        n_cnt   = '0;
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                if (r_m < CNT_W'(3)) begin
                    n_err   = STAT_FEW;
                    n_state = ST_ERR;
                end else begin
                    n_i     = CNT_W'(1);
                    n_state = ST_P_RD;
                end
            end
            ST_P_RD:  n_state = ST_P_LAT;
            ST_P_LAT: n_state = ST_P_DIV;
            ST_P_DIV: begin
                if (i_stat.h_bad) begin
                    n_err   = STAT_SPACING;
                    n_state = ST_ERR;
                end else begin
                    n_state = ST_P_WAIT;
                end
            end
            ST_P_WAIT: if (!i_stat.div_busy) n_state = ST_P_STORE;
            ST_P_STORE: begin
                if (r_i == r_m - CNT_W'(1)) begin
                    n_state = ST_SW_INIT;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_P_RD;
                end
            end
            ST_SW_INIT: begin
                n_i     = CNT_W'(1);
                n_ok    = 1'b1;
                n_sweep = '0;
                n_first = 1'b1;
                if (i_limit == '0) begin
                    n_stat  = STAT_LIMIT;
                    n_state = ST_O_RD;
                end else begin
                    n_state = ST_S_RD;
                end
            end
            ST_S_RD:    n_state = ST_S_A;
            ST_S_A:     n_state = ST_S_B;
            ST_S_B:     n_state = ST_S_C;
            ST_S_C:     n_state = ST_S_MUL1;
            ST_S_MUL1:  n_state = ST_S_MUL2;
            ST_S_MUL2:  n_state = ST_S_SUM;
            ST_S_SUM:   n_state = ST_S_DIV;
            ST_S_DIV:   n_state = ST_S_WAIT;
            ST_S_WAIT:  if (!i_stat.div_busy) n_state = ST_S_SAT;
            ST_S_SAT:   n_state = ST_S_DIFF;
            ST_S_DIFF:  n_state = ST_S_RELAX;
            ST_S_RELAX: begin
                if (i_stat.big_change) n_ok = 1'b0;
                n_state = ST_S_ROUND;
            end
            ST_S_ROUND: n_state = ST_S_WRITE;
            ST_S_WRITE: begin
                if (w_i_last) begin
                    n_state = ST_S_END;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_S_RD;
                end
            end
            ST_S_END: begin
                n_sweep = r_sweep + 8'd1;
                n_first = 1'b0;
                n_i     = CNT_W'(1);
                if (r_ok || r_sweep + 8'd1 == i_limit) begin
                    n_stat  = r_ok ? STAT_CONVERGED : STAT_LIMIT;
                    n_state = ST_O_RD;
                end else begin
                    n_ok    = 1'b1;
                    n_state = ST_S_RD;
                end
            end
            ST_O_RD: n_state = ST_O_PUT;
            ST_O_PUT: begin
                if (!i_stat.out_busy) begin
                    if (w_i_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = ST_O_RD;
                    end
                end
            end
            ST_ERR: if (!i_stat.out_busy) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.addr   = IDX_W'(r_i);
        o_cmd.zero   = 1'b0;
        o_cmd.status = r_stat;
        o_cmd.last   = 1'b0;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.addr = IDX_W'(r_cnt);
                if (i_in_valid && w_room) o_cmd.op = OP_STORE;
            end
            ST_P_RD:  o_cmd.addr = IDX_W'(r_i - CNT_W'(1));
            ST_P_LAT: o_cmd.op = OP_P_LATCH;
            ST_P_DIV: if (!i_stat.h_bad) o_cmd.op = OP_P_DIV;   // bad spacing: no divide
            ST_P_STORE: begin
                o_cmd.op   = w_i_one ? OP_P_FIRST : OP_P_RHS;
                o_cmd.addr = IDX_W'(r_i - CNT_W'(1));
            end
            ST_S_RD: o_cmd.addr = IDX_W'(r_i - CNT_W'(1));
            ST_S_A: begin
                o_cmd.op   = OP_S_A;
                o_cmd.zero = w_i_one;            // M at the left end
            end
            ST_S_B: begin
                o_cmd.op   = OP_S_B;
                o_cmd.zero = r_first;            // nothing written yet this solve
                o_cmd.addr = IDX_W'(r_i + CNT_W'(1));
            end
            ST_S_C: begin
                o_cmd.op   = OP_S_C;
                o_cmd.zero = r_first || w_i_last;
            end
            ST_S_MUL1:  o_cmd.op = OP_S_MUL1;
            ST_S_MUL2:  o_cmd.op = OP_S_MUL2;
            ST_S_SUM:   o_cmd.op = OP_S_SUM;
            ST_S_DIV:   o_cmd.op = OP_S_DIV;
            ST_S_SAT:   o_cmd.op = OP_S_SAT;
            ST_S_DIFF:  o_cmd.op = OP_S_DIFF;
            ST_S_RELAX: o_cmd.op = OP_S_RELAX;
            ST_S_ROUND: o_cmd.op = OP_S_ROUND;
            ST_S_WRITE: o_cmd.op = OP_S_WRITE;
            ST_O_PUT: begin
                o_cmd.zero = r_first;            // no sweep ran
                o_cmd.last = w_i_last;
                if (!i_stat.out_busy) o_cmd.op = OP_EMIT;
            end
            ST_ERR: begin
                o_cmd.addr   = '0;
                o_cmd.zero   = 1'b1;
                o_cmd.status = r_err;
                o_cmd.last   = 1'b1;
                if (!i_stat.out_busy) o_cmd.op = OP_EMIT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_m     <= '0;
            r_i     <= '0;
            r_sweep <= '0;
            r_ok    <= 1'b0;
            r_first <= 1'b1;
            r_err   <= STAT_FEW;
            r_stat  <= STAT_CONVERGED;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_m     <= n_m;
            r_i     <= n_i;
            r_sweep <= n_sweep;
            r_ok    <= n_ok;
            r_first <= n_first;
            r_err   <= n_err;
            r_stat  <= n_stat;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_EMIT |-> !i_stat.out_busy)
        else $error("result loaded over an untaken result");

    a_knot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_S_WRITE |-> r_i >= CNT_W'(1) && r_i + CNT_W'(2) <= r_m)
        else $error("sweep index outside interior knots");

    a_limit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_O_PUT && r_stat == STAT_LIMIT) |-> r_sweep == i_limit)
        else $error("limit status without all sweeps done");

endmodule

`default_nettype wire

// ===== hw/rtl/cubic_spline_gauss_seidel.sv =====
// Natural cubic spline second derivatives by relaxed Gauss-Seidel, Q15.16.
// Load: one knot item per cycle. Solve after the last item: slope prep over
// each interval, then sweeps over the interior knots, each knot waiting on the
// divider; output stalls while a result is not taken. Inputs are refused from
// the last item until the final result is loaded. Sync active-low reset: control
// and config registers to defaults, count cleared; memories are not cleared.
// Depends on csgs_pkg, csgs_ctrl, csgs_dp (csgs_div, csgs_ram).
`timescale 1ns / 1ps
`default_nettype none

module cubic_spline_gauss_seidel
    import csgs_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // knot items
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,   // [31:0] knot_x, [63:32] knot_y
    input  wire logic              s_axis_tlast,   // last_point
    // result items
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [39:0]            m_axis_tdata,   // [5:0] knot_index,
                                                   // [37:6] second_derivative, pad
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    output logic                   m_axis_tlast,   // last_result
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // config registers
    logic [7:0]  r_limit;
    logic [15:0] r_tol;
    logic [16:0] r_relax;
    logic        w_wr;
    logic [1:0]  w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'd50;
            r_tol   <= 16'd1;
            r_relax <= 17'd65536;
        end else if (w_wr) begin
            case (w_reg)
                REG_ITER:  r_limit <= pwdata[7:0];
                REG_TOL:   r_tol   <= pwdata[15:0];
                REG_RELAX: r_relax <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_ITER:  prdata = {24'd0, r_limit};
            REG_TOL:   prdata = {16'd0, r_tol};
            REG_RELAX: prdata = {15'd0, r_relax};
            default:   prdata = '0;
        endcase
    end

    // controller <-> datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    csgs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_limit    (r_limit),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    logic [IDX_W-1:0]   w_idx;
    logic signed [31:0] w_sd;

    csgs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_relax     (r_relax),
        .i_tol       (r_tol),
        .i_knot_x    (s_axis_tdata[31:0]),
        .i_knot_y    (s_axis_tdata[63:32]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_idx   (w_idx),
        .o_out_sd    (w_sd),
        .o_out_stat  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_sd, w_idx};

endmodule

`default_nettype wire
